@@ hw/rtl/vpi_pkg.sv @@
// ----------------------------------------------------------------------------
// vpi_pkg
// Shared types and constants for the Verlet particle integrator: item
// layouts, table entry layout, op codes, controller states, register map.
// ----------------------------------------------------------------------------
package vpi_pkg;

  // table geometry
  localparam int PARTICLE_COUNT = 16;
  localparam int ADDR_W         = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;

  // field widths
  localparam int IDX_W = 4;   // particle_index field
  localparam int POS_W = 24;  // unsigned Q0.24
  localparam int FIX_W = 32;  // signed Q8.24
  localparam int CFG_W = 24;  // dt and dt^2/2, unsigned Q0.24

  // configuration registers
  localparam int               APB_AW        = 3;
  localparam int               APB_DW        = 32;
  localparam logic [CFG_W-1:0] DT_RESET      = 24'd167772;
  localparam logic [CFG_W-1:0] HDT2_RESET    = 24'd839;
  localparam logic             CFG_IDX_DT    = 1'b0;
  localparam logic             CFG_IDX_HDT2  = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_CALC = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        particle_index;
    logic [POS_W-1:0]        load_pos_x;
    logic [POS_W-1:0]        load_pos_y;
    logic signed [FIX_W-1:0] load_vel_x;
    logic signed [FIX_W-1:0] load_vel_y;
    logic signed [FIX_W-1:0] new_acc_x;
    logic signed [FIX_W-1:0] new_acc_y;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_particle;
    logic [POS_W-1:0]        out_pos_x;
    logic [POS_W-1:0]        out_pos_y;
    logic signed [FIX_W-1:0] out_vel_x;
    logic signed [FIX_W-1:0] out_vel_y;
    logic signed [FIX_W-1:0] out_acc_x;
    logic signed [FIX_W-1:0] out_acc_y;
    logic                    wrapped_x;
    logic                    wrapped_y;
  } rsp_t;

  // one particle as stored in the table
  typedef struct packed {
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [FIX_W-1:0] vel_x;
    logic signed [FIX_W-1:0] vel_y;
    logic signed [FIX_W-1:0] acc_x;
    logic signed [FIX_W-1:0] acc_y;
  } entry_t;

endpackage

@@ hw/rtl/vpi_if.sv @@
// ----------------------------------------------------------------------------
// vpi_if
// Valid/ready item channels: command items in, result items out.
// ----------------------------------------------------------------------------
interface vpi_cmd_if import vpi_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface vpi_rsp_if import vpi_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/vpi_ram.sv @@
// ----------------------------------------------------------------------------
// vpi_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/vpi_axis.sv @@
// ----------------------------------------------------------------------------
// vpi_axis
// One axis of a velocity Verlet step: products registered on capture, then
// rounding, position wrap and velocity saturation.
// ----------------------------------------------------------------------------
module vpi_axis import vpi_pkg::*; (
  input  logic                    clk,
  input  logic                    capture,
  input  logic [POS_W-1:0]        pos,
  input  logic signed [FIX_W-1:0] vel,
  input  logic signed [FIX_W-1:0] acc,
  input  logic signed [FIX_W-1:0] acc_next,
  input  logic [CFG_W-1:0]        dt,
  input  logic [CFG_W-1:0]        hdt2,
  output logic [POS_W-1:0]        pos_next,
  output logic signed [FIX_W-1:0] vel_next,
  output logic                    wrapped
);

  logic signed [56:0] prod_v;   // vel * dt
  logic signed [56:0] prod_a;   // acc * dt^2/2
  logic signed [57:0] prod_dv;  // (acc + acc_next) * dt
  logic signed [32:0] acc_sum;

  logic [57:0] rnd_v;
  logic [57:0] rnd_a;
  logic [58:0] rnd_dv;
  logic [33:0] term_v;
  logic [33:0] term_a;
  logic [33:0] dv;
  logic [35:0] pos_sum;
  logic [34:0] vel_sum;

  assign acc_sum = {acc[FIX_W-1], acc} + {acc_next[FIX_W-1], acc_next};

  always_ff @(posedge clk) begin
    if (capture) begin
      prod_v  <= vel * $signed({1'b0, dt});
      prod_a  <= acc * $signed({1'b0, hdt2});
      prod_dv <= acc_sum * $signed({1'b0, dt});
    end
  end

  // round to nearest, ties up: add half an LSB, then arithmetic shift
  always_comb begin
    rnd_v   = {prod_v[56], prod_v} + (58'd1 << 23);
    rnd_a   = {prod_a[56], prod_a} + (58'd1 << 23);
    rnd_dv  = {prod_dv[57], prod_dv} + (59'd1 << 24);
    term_v  = rnd_v[57:24];
    term_a  = rnd_a[57:24];
    dv      = rnd_dv[58:25];
    pos_sum = {12'd0, pos} + {{2{term_v[33]}}, term_v} + {{2{term_a[33]}}, term_a};
    vel_sum = {{3{vel[FIX_W-1]}}, vel} + {dv[33], dv};
  end

  // position modulo 1; anything above bit 23 means the box edge was crossed
  assign pos_next = pos_sum[POS_W-1:0];
  assign wrapped  = |pos_sum[35:POS_W];

  always_comb begin
    if (vel_sum[34:31] == 4'b0000 || vel_sum[34:31] == 4'b1111) begin
      vel_next = vel_sum[FIX_W-1:0];
    end else if (vel_sum[34]) begin
      vel_next = {1'b1, {(FIX_W-1){1'b0}}};
    end else begin
      vel_next = {1'b0, {(FIX_W-1){1'b1}}};
    end
  end

endmodule

@@ hw/rtl/verlet_particle_integrator_core.sv @@
// ----------------------------------------------------------------------------
// verlet_particle_integrator_core
// Particle table (position, velocity, acceleration in 2-D) with load, read
// and velocity Verlet step items; periodic unit box, fixed point.
// ----------------------------------------------------------------------------
//
//  port    dir   handshake               carries
//  ------  ----  ----------------------  ---------------------------------
//  cmd     in    valid/ready             op, index, load values, new acc
//  rsp     out   valid/ready             entry after the item, wrap flags
//  apb     in    psel/penable/pwrite     dt_step @0x0, half_dt_squared @0x4
//
//  An item passes accept + table read, the product register, then
//  write-back and the result register. The registered read of the
//  table and the registered multipliers make these steps.
//  rst is synchronous; it clears the controller and the result valid,
//  and sets the two registers to their reset values. The table itself is not cleared.
//  While a finished result waits on rsp.ready, the next item can be taken;
//  it then stalls in the last stage until the result register frees up.
//
module verlet_particle_integrator_core import vpi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  vpi_cmd_if.sink            cmd,
  vpi_rsp_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] dt_step;
  logic [CFG_W-1:0] half_dt_squared;
  logic             cfg_wr;
  logic             cfg_sel;  // register index, word address bit

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      dt_step         <= DT_RESET;
      half_dt_squared <= HDT2_RESET;
    end else if (cfg_wr) begin
      if (cfg_sel == CFG_IDX_DT) begin
        dt_step <= pwdata[CFG_W-1:0];
      end else begin
        half_dt_squared <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_sel == CFG_IDX_DT) begin
      prdata = APB_DW'(dt_step);
    end else begin
      prdata = APB_DW'(half_dt_squared);
    end
  end

  // --------------------------------------------------------------------------
  // controller
  // --------------------------------------------------------------------------
  state_t state;
  state_t state_next;
  logic   cmd_take;
  logic   out_load;   // result register takes a new item this cycle
  logic   ram_we;
  cmd_t   cmd_q;      // item held for its whole trip
  logic   in_range;   // index lies inside the table

  assign cmd_take = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CALC;
      end
      S_CALC: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_q    <= cmd.payload;
      in_range <= (32'(cmd.payload.particle_index) < PARTICLE_COUNT);
    end
  end

  // --------------------------------------------------------------------------
  // particle table: read on accept, write back in the last stage
  // --------------------------------------------------------------------------
  entry_t ram_rdata;
  entry_t entry_new;

  vpi_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (PARTICLE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(cmd_q.particle_index)),
    .wdata (entry_new),
    .re    (cmd_take),
    .raddr (ADDR_W'(cmd.payload.particle_index)),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // per-axis step datapath; products captured the cycle the read data lands
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]        step_pos_x;
  logic [POS_W-1:0]        step_pos_y;
  logic signed [FIX_W-1:0] step_vel_x;
  logic signed [FIX_W-1:0] step_vel_y;
  logic                    step_wrap_x;
  logic                    step_wrap_y;

  vpi_axis u_axis_x (
    .clk      (clk),
    .capture  (state == S_READ),
    .pos      (ram_rdata.pos_x),
    .vel      (ram_rdata.vel_x),
    .acc      (ram_rdata.acc_x),
    .acc_next (cmd_q.new_acc_x),
    .dt       (dt_step),
    .hdt2     (half_dt_squared),
    .pos_next (step_pos_x),
    .vel_next (step_vel_x),
    .wrapped  (step_wrap_x)
  );

  vpi_axis u_axis_y (
    .clk      (clk),
    .capture  (state == S_READ),
    .pos      (ram_rdata.pos_y),
    .vel      (ram_rdata.vel_y),
    .acc      (ram_rdata.acc_y),
    .acc_next (cmd_q.new_acc_y),
    .dt       (dt_step),
    .hdt2     (half_dt_squared),
    .pos_next (step_pos_y),
    .vel_next (step_vel_y),
    .wrapped  (step_wrap_y)
  );

  // --------------------------------------------------------------------------
  // entry after the item; op 3 behaves as a read
  // --------------------------------------------------------------------------
  logic modifies;
  logic wrap_x;
  logic wrap_y;

  always_comb begin
    entry_new = ram_rdata;
    modifies  = 1'b0;
    wrap_x    = 1'b0;
    wrap_y    = 1'b0;
    case (op_t'(cmd_q.op))
      OP_LOAD: begin
        modifies        = 1'b1;
        entry_new.pos_x = cmd_q.load_pos_x;
        entry_new.pos_y = cmd_q.load_pos_y;
        entry_new.vel_x = cmd_q.load_vel_x;
        entry_new.vel_y = cmd_q.load_vel_y;
        entry_new.acc_x = cmd_q.new_acc_x;
        entry_new.acc_y = cmd_q.new_acc_y;
      end
      OP_STEP: begin
        modifies        = 1'b1;
        entry_new.pos_x = step_pos_x;
        entry_new.pos_y = step_pos_y;
        entry_new.vel_x = step_vel_x;
        entry_new.vel_y = step_vel_y;
        entry_new.acc_x = cmd_q.new_acc_x;
        entry_new.acc_y = cmd_q.new_acc_y;
        wrap_x          = step_wrap_x;
        wrap_y          = step_wrap_y;
      end
      default: begin
        modifies = 1'b0;
      end
    endcase
  end

  assign ram_we = out_load && in_range && modifies;

  // --------------------------------------------------------------------------
  // result register; out-of-range items report zeros beside the index
  // --------------------------------------------------------------------------
  rsp_t rsp_payload_next;

  always_comb begin
    rsp_payload_next              = '0;
    rsp_payload_next.out_particle = cmd_q.particle_index;
    if (in_range) begin
      rsp_payload_next.out_pos_x = entry_new.pos_x;
      rsp_payload_next.out_pos_y = entry_new.pos_y;
      rsp_payload_next.out_vel_x = entry_new.vel_x;
      rsp_payload_next.out_vel_y = entry_new.vel_y;
      rsp_payload_next.out_acc_x = entry_new.acc_x;
      rsp_payload_next.out_acc_y = entry_new.acc_y;
      rsp_payload_next.wrapped_x = wrap_x;
      rsp_payload_next.wrapped_y = wrap_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.payload <= rsp_payload_next;
    end
  end

`ifndef SYNTHESIS
  // an accepted item passes S_READ and then reaches the last stage
  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> ##1 (state == S_CALC))
    else $error("accepted item did not reach the result stage");

  // the result register is never overwritten while its item waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!rsp.valid || rsp.ready))
    else $error("result register loaded while still holding an item");

  // table writes happen only as an item leaves the last stage
  a_write_in_calc: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CALC) && (state_next == S_IDLE))
    else $error("table written outside the result stage");

  // a new result appears only after the last stage
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(state) == S_CALC))
    else $error("result valid without a finished item");
`endif

endmodule
